// ===== rtl/dhg_pkg.sv =====
// dhg_pkg: shared types and fixed constants of the DVFS/hotplug governor.
// No dependencies.
`timescale 1ns / 1ps

package dhg_pkg;

  typedef enum logic [2:0] {
    CFG_HARD_THRESHOLD = 3'd0,
    CFG_EASY_THRESHOLD = 3'd1,
    CFG_EASY_TICKS     = 3'd2,
    CFG_DOWN_TICKS     = 3'd3,
    CFG_UNPLUG_TICKS   = 3'd4,
    CFG_MIN_LEVEL      = 3'd5,
    CFG_MAX_LEVEL      = 3'd6,
    CFG_HOTPLUG_ENABLE = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_RAISE = 2'd1,
    DIR_LOWER = 2'd2
  } scale_dir_t;

  localparam logic [6:0]  RST_HARD_THRESHOLD = 7'd90;
  localparam logic [6:0]  RST_EASY_THRESHOLD = 7'd75;
  localparam logic [15:0] RST_EASY_TICKS     = 16'd48;
  localparam logic [15:0] RST_DOWN_TICKS     = 16'd24;
  localparam logic [15:0] RST_UNPLUG_TICKS   = 16'd100;
  localparam logic [2:0]  RST_CORE_GOAL      = 3'd4;

  // load-sum thresholds for plugging a core in
  localparam logic [8:0]  PLUG_SUM_THREE     = 9'd180;
  localparam logic [8:0]  PLUG_SUM_TWO       = 9'd120;

  localparam logic [15:0] CNT_MAX            = 16'hFFFF;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

// ===== rtl/dvfs_hotplug_governor.sv =====
// dvfs_hotplug_governor: per-tick frequency and core on/off decision.
// Depends on dhg_pkg.
`timescale 1ns / 1ps
//
//  channel | ports                                   | dir | handshake
//  --------+-----------------------------------------+-----+----------
//  in      | in_cur_level .. in_online_mask          | in  | in_valid/in_ready
//  out     | out_target_level .. out_plug_on         | out | out_valid/out_ready
//  cfg     | cfg_index, cfg_data                     | in  | cfg_valid/cfg_ready
//
// One word enters the input register, the decision logic sits between it and
// the result register. One word per cycle sustained while out_ready stays high.
// Governor state updates when a word moves into the result register.
// Output stall holds the result register; the input register still takes a
// word when the result register frees up in the same cycle.
// Reset (synchronous, rst_n low) restores control, config and state; not payload.

module dvfs_hotplug_governor #(
  parameter logic [15:0] HIGH_LEVEL = 16'd1100,
  parameter logic [15:0] LOW_LEVEL  = 16'd800
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [15:0]                in_cur_level,
  input  logic [6:0]                 in_peak_load,
  input  logic [6:0]                 in_load_first,
  input  logic [6:0]                 in_load_second,
  input  logic [6:0]                 in_load_third,
  input  logic [3:0]                 in_online_mask,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [15:0]                out_target_level,
  output logic [1:0]                 out_scale_dir,
  output logic                       out_plug_request,
  output logic [1:0]                 out_plug_core,
  output logic                       out_plug_on,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [15:0]                cfg_data
);
  import dhg_pkg::*;

  // lowering allowed when peak*HIGH*120/10000 <= LOW, i.e. product < (LOW+1)*10000
  localparam logic [22:0] HIGH_X120   = 23'(HIGH_LEVEL * 120);
  localparam logic [29:0] LOWER_LIMIT = 30'((LOW_LEVEL + 1) * 10000);

  // configuration
  logic [6:0]  hard_thr_r, easy_thr_r;
  logic [15:0] easy_ticks_r, down_ticks_r, unplug_ticks_r;
  logic [15:0] min_level_r, max_level_r;
  logic        hp_en_r;

  // governor state
  logic [6:0]  act_thr_r, act_thr_nxt;
  logic [15:0] easy_cnt_r, easy_cnt_nxt;
  logic [15:0] down_cnt_r, down_cnt_nxt;
  logic [15:0] plug_cnt_r, plug_cnt_nxt;
  logic [2:0]  core_goal_r, core_goal_nxt;
  logic [15:0] last_level_r, last_level_nxt;

  // input register
  logic        s1_valid_r;
  logic [15:0] s1_cur_r;
  logic [6:0]  s1_peak_r, s1_l0_r, s1_l1_r, s1_l2_r;
  logic [3:0]  s1_mask_r;

  logic        advance;
  logic [15:0] target_nxt;
  scale_dir_t  dir_nxt;
  logic        req_nxt, on_nxt;
  logic [1:0]  core_nxt;

  assign advance   = s1_valid_r && (!out_valid || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  // decision logic
  logic [15:0] easy_inc, down_inc, plug_inc;
  logic [29:0] scaled;
  logic        decided;
  logic [15:0] tgt_raw, tgt_lo;
  logic [2:0]  count;
  logic [8:0]  load_sum;
  logic [8:0]  sum_thr;

  always_comb begin
    act_thr_nxt    = act_thr_r;
    easy_cnt_nxt   = easy_cnt_r;
    down_cnt_nxt   = down_cnt_r;
    plug_cnt_nxt   = plug_cnt_r;
    core_goal_nxt  = core_goal_r;
    last_level_nxt = last_level_r;
    target_nxt     = HIGH_LEVEL;
    dir_nxt        = DIR_RAISE;
    req_nxt        = 1'b0;
    core_nxt       = 2'd0;
    on_nxt         = 1'b0;
    decided        = 1'b0;
    tgt_raw        = '0;
    tgt_lo         = '0;
    easy_inc       = sat_inc(easy_cnt_r);
    down_inc       = sat_inc(down_cnt_r);
    scaled         = 30'(s1_peak_r) * 30'(HIGH_X120);
    count          = 3'(s1_mask_r[0]) + 3'(s1_mask_r[1]) + 3'(s1_mask_r[2])
                   + 3'(s1_mask_r[3]);
    load_sum       = 9'(s1_l0_r) + 9'(s1_l1_r)
                   + ((count == 3'd3) ? 9'(s1_l2_r) : 9'd0);
    sum_thr        = (count == 3'd3) ? PLUG_SUM_THREE : PLUG_SUM_TWO;
    plug_inc       = '0;

    if (s1_cur_r != '0) begin
      // easy-threshold window
      if (act_thr_r == easy_thr_r) begin
        easy_cnt_nxt = easy_inc;
        if (easy_inc >= easy_ticks_r) begin
          act_thr_nxt  = hard_thr_r;
          easy_cnt_nxt = '0;
        end
        if (s1_cur_r == HIGH_LEVEL) easy_cnt_nxt = '0;
      end else begin
        easy_cnt_nxt = '0;
      end

      if (s1_peak_r > act_thr_nxt) begin
        tgt_raw      = HIGH_LEVEL;
        decided      = 1'b1;
        down_cnt_nxt = '0;
        act_thr_nxt  = easy_thr_r;
      end else begin
        down_cnt_nxt = down_inc;
        if (s1_cur_r > LOW_LEVEL && down_inc >= down_ticks_r) begin
          down_cnt_nxt = '0;
          if (scaled < LOWER_LIMIT) begin
            tgt_raw = LOW_LEVEL;
            decided = 1'b1;
          end
        end
      end

      tgt_lo = (tgt_raw < min_level_r) ? min_level_r : tgt_raw;
      if (decided) target_nxt = (tgt_lo > max_level_r) ? max_level_r : tgt_lo;
      else         target_nxt = s1_cur_r;

      if (target_nxt > s1_cur_r)      dir_nxt = DIR_RAISE;
      else if (target_nxt < s1_cur_r) dir_nxt = DIR_LOWER;
      else                            dir_nxt = DIR_NONE;

      // hotplug
      if (hp_en_r) begin
        if (s1_cur_r != last_level_r) begin
          if (last_level_r != LOW_LEVEL) plug_cnt_nxt = '0;
          last_level_nxt = s1_cur_r;
        end
        plug_inc = sat_inc(plug_cnt_nxt);
        if (s1_cur_r == HIGH_LEVEL) begin
          if (load_sum >= sum_thr && count < 3'd4)
            core_goal_nxt = (count == 3'd3) ? 3'd4 : 3'd3;
          plug_cnt_nxt = '0;
        end else begin
          plug_cnt_nxt = plug_inc;
          if (plug_inc >= unplug_ticks_r) begin
            if (count == 3'd4) begin
              core_goal_nxt = 3'd3;
              plug_cnt_nxt  = '0;
            end else if (count == 3'd3) begin
              core_goal_nxt = 3'd2;
              plug_cnt_nxt  = '0;
            end
          end
        end

        if (count < core_goal_nxt) begin
          // lowest offline core among 1..3
          if (!s1_mask_r[1]) begin
            req_nxt = 1'b1; core_nxt = 2'd1; on_nxt = 1'b1;
          end else if (!s1_mask_r[2]) begin
            req_nxt = 1'b1; core_nxt = 2'd2; on_nxt = 1'b1;
          end else if (!s1_mask_r[3]) begin
            req_nxt = 1'b1; core_nxt = 2'd3; on_nxt = 1'b1;
          end
        end else if (count > core_goal_nxt) begin
          // highest online core among 3..1
          if (s1_mask_r[3]) begin
            req_nxt = 1'b1; core_nxt = 2'd3;
          end else if (s1_mask_r[2]) begin
            req_nxt = 1'b1; core_nxt = 2'd2;
          end else if (s1_mask_r[1]) begin
            req_nxt = 1'b1; core_nxt = 2'd1;
          end
        end
      end
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid      <= 1'b0;
      hard_thr_r     <= RST_HARD_THRESHOLD;
      easy_thr_r     <= RST_EASY_THRESHOLD;
      easy_ticks_r   <= RST_EASY_TICKS;
      down_ticks_r   <= RST_DOWN_TICKS;
      unplug_ticks_r <= RST_UNPLUG_TICKS;
      min_level_r    <= LOW_LEVEL;
      max_level_r    <= HIGH_LEVEL;
      hp_en_r        <= 1'b1;
      act_thr_r      <= RST_HARD_THRESHOLD;
      easy_cnt_r     <= '0;
      down_cnt_r     <= '0;
      plug_cnt_r     <= '0;
      core_goal_r    <= RST_CORE_GOAL;
      last_level_r   <= '0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (advance)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (advance) begin
        act_thr_r    <= act_thr_nxt;
        easy_cnt_r   <= easy_cnt_nxt;
        down_cnt_r   <= down_cnt_nxt;
        plug_cnt_r   <= plug_cnt_nxt;
        core_goal_r  <= core_goal_nxt;
        last_level_r <= last_level_nxt;
      end

      // writes must arrive only while idle; the block itself does not enforce it
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_HARD_THRESHOLD: begin
            if (act_thr_r == hard_thr_r) act_thr_r <= cfg_data[6:0];
            hard_thr_r <= cfg_data[6:0];
          end
          CFG_EASY_THRESHOLD: begin
            if (act_thr_r == easy_thr_r) act_thr_r <= cfg_data[6:0];
            easy_thr_r <= cfg_data[6:0];
          end
          CFG_EASY_TICKS:     easy_ticks_r   <= cfg_data;
          CFG_DOWN_TICKS:     down_ticks_r   <= cfg_data;
          CFG_UNPLUG_TICKS:   unplug_ticks_r <= cfg_data;
          CFG_MIN_LEVEL:      min_level_r    <= cfg_data;
          CFG_MAX_LEVEL:      max_level_r    <= cfg_data;
          CFG_HOTPLUG_ENABLE: hp_en_r        <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cur_r  <= in_cur_level;
      s1_peak_r <= in_peak_load;
      s1_l0_r   <= in_load_first;
      s1_l1_r   <= in_load_second;
      s1_l2_r   <= in_load_third;
      s1_mask_r <= in_online_mask;
    end
    if (advance) begin
      out_target_level <= target_nxt;
      out_scale_dir    <= dir_nxt;
      out_plug_request <= req_nxt;
      out_plug_core    <= core_nxt;
      out_plug_on      <= on_nxt;
    end
  end

endmodule

// ===== sim/dvfs_hotplug_governor_test.sv =====
// dvfs_hotplug_governor_test: self-checking bench for the DVFS/hotplug governor.
// Carries its own per-tick governor model in a scoreboard class; needs dhg_pkg
// and dvfs_hotplug_governor.
`timescale 1ns / 1ps

module dvfs_hotplug_governor_test;
  import dhg_pkg::*;

  localparam logic [15:0] HIGH_LEVEL  = 16'd1100;
  localparam logic [15:0] LOW_LEVEL   = 16'd800;
  localparam int          QUIET_LIMIT = 5000;
  localparam int          PHASE_TICKS = 200;

  typedef struct packed {
    logic [15:0] cur;
    logic [6:0]  peak;
    logic [6:0]  l0;
    logic [6:0]  l1;
    logic [6:0]  l2;
    logic [3:0]  mask;
  } tick_t;

  typedef struct packed {
    logic [15:0] level;
    logic [1:0]  dir;
    logic        req;
    logic [1:0]  core;
    logic        on;
  } decision_t;

  class governor_scoreboard;
    logic [6:0]  hard_thr, easy_thr, active_thr;
    logic [15:0] easy_ticks, down_ticks, unplug_ticks, min_lvl, max_lvl;
    logic        hp_en;
    logic [15:0] easy_cnt, down_cnt, plug_cnt, last_lvl;
    logic [2:0]  core_goal;
    decision_t   pending[$];
    decision_t   last;
    int unsigned mismatches, checked;
    int unsigned n_raise, n_lower, n_plug_on, n_plug_off;

    function new();
      hard_thr = RST_HARD_THRESHOLD;
      easy_thr = RST_EASY_THRESHOLD;
      easy_ticks = RST_EASY_TICKS;
      down_ticks = RST_DOWN_TICKS;
      unplug_ticks = RST_UNPLUG_TICKS;
      min_lvl = LOW_LEVEL;
      max_lvl = HIGH_LEVEL;
      hp_en = 1'b1;
      active_thr = RST_HARD_THRESHOLD;
      easy_cnt = '0;
      down_cnt = '0;
      plug_cnt = '0;
      last_lvl = '0;
      core_goal = RST_CORE_GOAL;
      last = '0;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [15:0] data);
      case (idx)
        CFG_HARD_THRESHOLD: begin
          if (active_thr == hard_thr) active_thr = data[6:0];
          hard_thr = data[6:0];
        end
        CFG_EASY_THRESHOLD: begin
          if (active_thr == easy_thr) active_thr = data[6:0];
          easy_thr = data[6:0];
        end
        CFG_EASY_TICKS:     easy_ticks = data;
        CFG_DOWN_TICKS:     down_ticks = data;
        CFG_UNPLUG_TICKS:   unplug_ticks = data;
        CFG_MIN_LEVEL:      min_lvl = data;
        CFG_MAX_LEVEL:      max_lvl = data;
        CFG_HOTPLUG_ENABLE: hp_en = data[0];
        default: ;
      endcase
    endfunction

    // one governor tick: frequency decision, then hotplug decision
    function void note_tick(tick_t t);
      decision_t   d;
      logic [15:0] lvl;
      logic [31:0] scaled;
      logic [2:0]  n_on;
      logic [8:0]  sum, thr;
      logic        decided;
      int          k;
      d = '0;
      if (t.cur == 16'd0) begin
        d.level = HIGH_LEVEL;
        d.dir = DIR_RAISE;
      end else begin
        if (active_thr == easy_thr) begin
          easy_cnt = bump(easy_cnt);
          if (easy_cnt >= easy_ticks) begin
            active_thr = hard_thr;
            easy_cnt = '0;
          end
          if (t.cur == HIGH_LEVEL) easy_cnt = '0;
        end else begin
          easy_cnt = '0;
        end

        decided = 1'b0;
        lvl = '0;
        if (t.peak > active_thr) begin
          lvl = HIGH_LEVEL;
          decided = 1'b1;
          down_cnt = '0;
          active_thr = easy_thr;
        end else begin
          down_cnt = bump(down_cnt);
          if (t.cur > LOW_LEVEL && down_cnt >= down_ticks) begin
            down_cnt = '0;
            scaled = 32'(t.peak) * 32'(HIGH_LEVEL) * 32'd120 / 32'd10000;
            if (scaled <= 32'(LOW_LEVEL)) begin
              lvl = LOW_LEVEL;
              decided = 1'b1;
            end
          end
        end
        if (decided) begin
          if (lvl < min_lvl) lvl = min_lvl;
          if (lvl > max_lvl) lvl = max_lvl;
        end else begin
          lvl = t.cur;
        end
        d.level = lvl;
        if (d.level > t.cur) d.dir = DIR_RAISE;
        else if (d.level < t.cur) d.dir = DIR_LOWER;
        else d.dir = DIR_NONE;

        if (hp_en) begin
          n_on = 3'($countones(t.mask));
          if (t.cur != last_lvl) begin
            if (last_lvl != LOW_LEVEL) plug_cnt = '0;
            last_lvl = t.cur;
          end
          if (t.cur == HIGH_LEVEL) begin
            sum = 9'(t.l0) + 9'(t.l1) + ((n_on == 3'd3) ? 9'(t.l2) : 9'd0);
            thr = (n_on == 3'd3) ? PLUG_SUM_THREE : PLUG_SUM_TWO;
            if (sum >= thr && n_on < 3'd4) core_goal = (n_on == 3'd3) ? 3'd4 : 3'd3;
            plug_cnt = '0;
          end else begin
            plug_cnt = bump(plug_cnt);
            if (plug_cnt >= unplug_ticks) begin
              if (n_on == 3'd4) begin
                core_goal = 3'd3;
                plug_cnt = '0;
              end else if (n_on == 3'd3) begin
                core_goal = 3'd2;
                plug_cnt = '0;
              end
            end
          end
          // lowest offline core goes on, highest online core goes off
          if (n_on < core_goal) begin
            for (k = 1; k < 4; k++) begin
              if (!d.req && !t.mask[k]) begin
                d.req = 1'b1;
                d.core = k[1:0];
                d.on = 1'b1;
              end
            end
          end else if (n_on > core_goal) begin
            for (k = 3; k > 0; k--) begin
              if (!d.req && t.mask[k]) begin
                d.req = 1'b1;
                d.core = k[1:0];
                d.on = 1'b0;
              end
            end
          end
        end
      end
      if (d.dir == DIR_RAISE) n_raise++;
      if (d.dir == DIR_LOWER) n_lower++;
      if (d.req && d.on) n_plug_on++;
      if (d.req && !d.on) n_plug_off++;
      last = d;
      pending.push_back(d);
    endfunction

    function void check_decision(decision_t got);
      decision_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing pending: level %0d dir %0d", $time,
                   got.level, got.dir);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.level !== want.level || got.dir !== want.dir || got.req !== want.req ||
          got.core !== want.core || got.on !== want.on) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: word %0d exp/got level %0d/%0d dir %0d/%0d req %0b/%0b",
                    " core %0d/%0d on %0b/%0b"},
                   $time, checked, want.level, got.level, want.dir, got.dir, want.req, got.req,
                   want.core, got.core, want.on, got.on);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_cur_level = '0;
  logic [6:0]  in_peak_load = '0;
  logic [6:0]  in_load_first = '0;
  logic [6:0]  in_load_second = '0;
  logic [6:0]  in_load_third = '0;
  logic [3:0]  in_online_mask = 4'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_target_level;
  logic [1:0]  out_scale_dir;
  logic        out_plug_request;
  logic [1:0]  out_plug_core;
  logic        out_plug_on;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  governor_scoreboard sb = new();
  logic        calm = 1'b0;
  logic [3:0]  plug_mask = 4'b1111;
  int          quiet = 0;
  int unsigned n_ticks = 0;
  int unsigned n_cfg = 0;

  dvfs_hotplug_governor #(
    .HIGH_LEVEL(HIGH_LEVEL),
    .LOW_LEVEL (LOW_LEVEL)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cur_level    (in_cur_level),
    .in_peak_load    (in_peak_load),
    .in_load_first   (in_load_first),
    .in_load_second  (in_load_second),
    .in_load_third   (in_load_third),
    .in_online_mask  (in_online_mask),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_target_level(out_target_level),
    .out_scale_dir   (out_scale_dir),
    .out_plug_request(out_plug_request),
    .out_plug_core   (out_plug_core),
    .out_plug_on     (out_plug_on),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: check each accepted word, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_decision('{level: out_target_level, dir: out_scale_dir,
                            req: out_plug_request, core: out_plug_core, on: out_plug_on});
      out_ready <= calm || ($urandom_range(0, 99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles, %0d words pending", QUIET_LIMIT,
             sb.pending.size());
    $display("FAIL");
    $finish;
  end

  function automatic tick_t mk_tick(logic [15:0] cur, logic [6:0] peak, logic [6:0] l0,
                                    logic [6:0] l1, logic [6:0] l2, logic [3:0] mask);
    tick_t t;
    t.cur = cur;
    t.peak = peak;
    t.l0 = l0;
    t.l1 = l1;
    t.l2 = l2;
    t.mask = mask;
    return t;
  endfunction

  function automatic logic [7:0][15:0] make_settings(
      logic [6:0] hard, logic [6:0] easy, logic [15:0] easy_t, logic [15:0] down_t,
      logic [15:0] unplug_t, logic [15:0] lo, logic [15:0] hi, logic en);
    logic [7:0][15:0] v;
    v[CFG_HARD_THRESHOLD] = {9'd0, hard};
    v[CFG_EASY_THRESHOLD] = {9'd0, easy};
    v[CFG_EASY_TICKS]     = easy_t;
    v[CFG_DOWN_TICKS]     = down_t;
    v[CFG_UNPLUG_TICKS]   = unplug_t;
    v[CFG_MIN_LEVEL]      = lo;
    v[CFG_MAX_LEVEL]      = hi;
    v[CFG_HOTPLUG_ENABLE] = {15'd0, en};
    return v;
  endfunction

  // mostly a plausible governor loop: frequency and core mask follow the
  // previous decision; some words are pure noise
  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned r;
    logic [6:0]  top;
    if (sb.last.req) plug_mask[sb.last.core] = sb.last.on;
    if (plug_mask == 4'd0) plug_mask = 4'b0001;
    t.l0 = 7'($urandom_range(0, 100));
    t.l1 = 7'($urandom_range(0, 100));
    t.l2 = 7'($urandom_range(0, 100));
    if ($urandom_range(0, 99) < 15) begin
      t.cur = 16'($urandom_range(0, 65535));
      t.peak = 7'($urandom_range(0, 100));
      t.mask = 4'($urandom_range(1, 15));
      return t;
    end
    r = $urandom_range(0, 99);
    if (r < 65 && sb.last.level != 16'd0) t.cur = sb.last.level;
    else if (r < 78) t.cur = HIGH_LEVEL;
    else if (r < 86) t.cur = LOW_LEVEL;
    else if (r < 92) t.cur = 16'd900 + 16'(100 * $urandom_range(0, 1));
    else if (r < 97) t.cur = 16'($urandom_range(1, 65535));
    else if (r < 99) t.cur = 16'd0;
    else t.cur = 16'hFFFF;
    if ($urandom_range(0, 99) < 10) plug_mask = 4'($urandom_range(1, 15));
    t.mask = plug_mask;
    top = (t.l0 > t.l1) ? t.l0 : t.l1;
    if (t.l2 > top) top = t.l2;
    t.peak = ($urandom_range(0, 99) < 55) ? top : 7'($urandom_range(0, 100));
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cur_level <= t.cur;
    in_peak_load <= t.peak;
    in_load_first <= t.l0;
    in_load_second <= t.l1;
    in_load_third <= t.l2;
    in_online_mask <= t.mask;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t);
    n_ticks++;
  endtask

  // stop sending and wait until every pending word is back
  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // write all eight registers, starting at a rotating index
  task automatic program_regs(logic [7:0][15:0] v, int start);
    int       k;
    cfg_idx_t idx;
    for (k = 0; k < 8; k++) begin
      idx = cfg_idx_t'((k + start) % 8);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= v[idx];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx, v[idx]);
      n_cfg++;
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int ph;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unknown frequency, field extremes, plug-in thresholds
    send_tick(mk_tick(16'd0, 7'd100, 7'd100, 7'd100, 7'd100, 4'd15));
    send_tick(mk_tick(16'hFFFF, 7'd0, 7'd0, 7'd0, 7'd0, 4'd1));
    send_tick(mk_tick(HIGH_LEVEL, 7'd100, 7'd100, 7'd100, 7'd100, 4'b0011));
    send_tick(mk_tick(HIGH_LEVEL, 7'd91, 7'd60, 7'd60, 7'd60, 4'b0111));
    send_tick(mk_tick(HIGH_LEVEL, 7'd100, 7'd100, 7'd100, 7'd100, 4'b1111));
    send_tick(mk_tick(16'd1, 7'd90, 7'd0, 7'd0, 7'd0, 4'b1111));
    send_tick(mk_tick(LOW_LEVEL, 7'd75, 7'd0, 7'd100, 7'd0, 4'b0010));
    send_tick(mk_tick(HIGH_LEVEL, 7'd0, 7'd100, 7'd100, 7'd0, 4'b1000));
    send_tick(mk_tick(HIGH_LEVEL, 7'd50, 7'd59, 7'd60, 7'd100, 4'b0101));

    // immediate lowering, scaled-load limit, fast unplug
    drain(4);
    program_regs(make_settings(7'd100, 7'd75, 16'd0, 16'd0, 16'd1, 16'd0, 16'hFFFF, 1'b1), 0);
    send_tick(mk_tick(16'd1000, 7'd60, 7'd10, 7'd10, 7'd10, 4'b1111));
    send_tick(mk_tick(16'd1000, 7'd61, 7'd10, 7'd10, 7'd10, 4'b1111));
    send_tick(mk_tick(16'd900, 7'd100, 7'd0, 7'd0, 7'd0, 4'b1111));
    send_tick(mk_tick(LOW_LEVEL, 7'd0, 7'd0, 7'd0, 7'd0, 4'b1111));
    send_tick(mk_tick(LOW_LEVEL, 7'd0, 7'd0, 7'd0, 7'd0, 4'b0111));
    send_tick(mk_tick(LOW_LEVEL, 7'd0, 7'd0, 7'd0, 7'd0, 4'b0011));

    // clamp window collapsed to zero, hotplug off
    drain(4);
    program_regs(make_settings(7'd0, 7'd0, 16'd5, 16'd0, 16'd1, 16'd0, 16'd0, 1'b0), 7);
    send_tick(mk_tick(16'd500, 7'd100, 7'd100, 7'd100, 7'd100, 4'b0001));
    send_tick(mk_tick(16'd500, 7'd0, 7'd0, 7'd0, 7'd0, 4'b1111));
    send_tick(mk_tick(HIGH_LEVEL, 7'd1, 7'd100, 7'd100, 7'd100, 4'b0011));

    for (ph = 0; ph < 7; ph++) begin
      drain(4);
      case (ph)
        0: program_regs(make_settings(RST_HARD_THRESHOLD, RST_EASY_THRESHOLD,
                                      RST_EASY_TICKS, RST_DOWN_TICKS, RST_UNPLUG_TICKS,
                                      LOW_LEVEL, HIGH_LEVEL, 1'b1), $urandom_range(0, 7));
        1: program_regs(make_settings(7'd80, 7'd50, 16'd2, 16'd3, 16'd4, LOW_LEVEL,
                                      HIGH_LEVEL, 1'b1), $urandom_range(0, 7));
        2: program_regs(make_settings(7'd0, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0),
                        $urandom_range(0, 7));
        3: program_regs(make_settings(7'd100, 7'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      16'hFFFF, 16'hFFFF, 1'b1), $urandom_range(0, 7));
        4: program_regs(make_settings(7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)),
                                      16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                                      16'($urandom_range(0, 10)),
                                      16'($urandom_range(0, 1200)),
                                      16'($urandom_range(600, 65535)), 1'b1),
                        $urandom_range(0, 7));
        5: program_regs(make_settings(7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      1'($urandom_range(0, 1))),
                        $urandom_range(0, 7));
        default: begin
          n = $urandom_range(0, 100);
          // equal thresholds keep the easy window permanently open
          program_regs(make_settings(7'(n), 7'(n), 16'($urandom_range(0, 4)),
                                     16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)),
                                     16'($urandom_range(700, 900)),
                                     16'($urandom_range(1000, 1200)),
                                     1'($urandom_range(0, 1))),
                       $urandom_range(0, 7));
        end
      endcase
      for (n = 0; n < PHASE_TICKS; n++) begin
        calm = (ph == 1 && n < 150);
        if (ph == 3 && n == 100) drain(0);
        send_tick(random_tick());
      end
      calm = 1'b0;
    end

    drain(10);
    if (sb.pending.size() != 0)
      $display("%0d expected words never arrived", sb.pending.size());
    $display("%0d ticks checked over 10 register settings (%0d register writes)",
             sb.checked, n_cfg);
    $display("decisions: %0d raise, %0d lower, %0d core on, %0d core off, %0d mismatches",
             sb.n_raise, sb.n_lower, sb.n_plug_on, sb.n_plug_off, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0 && sb.checked == n_ticks) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dhg_pkg.sv
rtl/dvfs_hotplug_governor.sv
sim/dvfs_hotplug_governor_test.sv
